[sv/bfbc_pkg.sv]
package bfbc_pkg;

  localparam int VALUE_W     = 64;
  localparam int WORD_W      = 63;
  localparam int CNT_W       = 4;
  localparam int NUM_COLS    = 8;
  localparam int COL_W       = 8;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int FIELD_W     = WORD_W + CNT_W + NUM_COLS * COL_W;
  localparam int OUT_TDATA_W = ((FIELD_W + 7) / 8) * 8;

  localparam logic [10:0] EXP_BIAS    = 11'd1023;
  localparam logic [5:0]  HIDDEN_SPAN = 6'd53;
  localparam logic [5:0]  MANT_TOP    = 6'd52;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEC_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WHOLE_WIDTH = 2'd2;

  typedef struct packed {
    logic        sgn;
    logic [63:0] mag;
    logic [63:0] frac;
  } split_t;

  typedef struct packed {
    logic        sgn;
    logic [63:0] offs;
    logic [63:0] frac;
  } offset_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  cnt;
  } packed_t;

  typedef struct packed {
    logic [NUM_COLS-1:0][COL_W-1:0] cols;
    logic [CNT_W-1:0]               cnt;
    logic [WORD_W-1:0]              word;
  } result_t;

endpackage

[sv/bounded_float_byte_column_encoder.sv]
// Bounded float byte column encoder.
// Input stream s_axis_*: one IEEE double bit pattern per transaction.
// Output stream m_axis_*: one packed result per input transaction, in order.
// The configuration port writes lower_bound, dec_width and whole_width; write
// it only while no transaction is in flight.
// Four register stages: mantissa split, offset add, field packing, byte
// column slicing. One transaction per cycle is sustained while m_axis_tready
// stays high, set by the per-stage registers.
// Each stage holds its item while the next one is full, so a stall on
// m_axis_tready fills the bubbles and then holds s_axis_tready low; no data
// is lost or repeated.
// Reset clears all stage valid flags and returns the registers to
// lower_bound 0, dec_width 0, whole_width 1.
module bounded_float_byte_column_encoder (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // value_bits[63:0]
  input  logic [bfbc_pkg::VALUE_W-1:0]         s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // packed_word[62:0], column_count[66:63], col_0[74:67] .. col_7[130:123], zero pad
  output logic [bfbc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                 cfg_wr_en,
  input  logic [bfbc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bfbc_pkg::CFG_W-1:0]           cfg_data
);

  logic [63:0]       neg_lower_bound;
  logic [5:0]        dec_width;
  logic [5:0]        whole_width;

  logic              v1, v2, v3;
  logic              r1, r2, r3;
  bfbc_pkg::split_t  d1;
  bfbc_pkg::offset_t d2;
  bfbc_pkg::packed_t d3;
  bfbc_pkg::result_t d4;

  // The lower bound is kept negated so the offset stage needs one adder.
  always_ff @(posedge clk) begin
    if (rst) begin
      neg_lower_bound <= '0;
      dec_width       <= '0;
      whole_width     <= 6'd1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bfbc_pkg::CFG_LOWER_BOUND: neg_lower_bound <= 64'd0 - cfg_data;
        bfbc_pkg::CFG_DEC_WIDTH:   dec_width       <= cfg_data[5:0];
        bfbc_pkg::CFG_WHOLE_WIDTH: whole_width     <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  bfbc_split u_split (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .value_bits (s_axis_tdata),
    .dec_width  (dec_width),
    .out_valid  (v1),
    .out_ready  (r1),
    .out_data   (d1)
  );

  bfbc_offset u_offset (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (v1),
    .in_ready        (r1),
    .in_data         (d1),
    .neg_lower_bound (neg_lower_bound),
    .out_valid       (v2),
    .out_ready       (r2),
    .out_data        (d2)
  );

  bfbc_pack u_pack (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (v2),
    .in_ready    (r2),
    .in_data     (d2),
    .dec_width   (dec_width),
    .whole_width (whole_width),
    .out_valid   (v3),
    .out_ready   (r3),
    .out_data    (d3)
  );

  bfbc_columns u_columns (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (v3),
    .in_ready    (r3),
    .in_data     (d3),
    .whole_width (whole_width),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (d4)
  );

  assign m_axis_tdata = {{(bfbc_pkg::OUT_TDATA_W - bfbc_pkg::FIELD_W){1'b0}}, d4};

endmodule

[sv/bfbc_split.sv]
module bfbc_split (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [63:0]       value_bits,
  input  logic [5:0]        dec_width,
  output logic              out_valid,
  input  logic              out_ready,
  output bfbc_pkg::split_t  out_data
);

  logic [10:0]      expf;
  logic [63:0]      mant64;
  logic [63:0]      full;
  logic [11:0]      ep;
  logic [11:0]      shl;
  logic [10:0]      ne;
  logic [63:0]      f0;
  bfbc_pkg::split_t data_next;

  always_comb begin
    expf   = value_bits[62:52];
    mant64 = {12'd0, value_bits[51:0]};
    full   = {11'd0, 1'b1, value_bits[51:0]};
    ep     = {1'b0, expf} - {1'b0, bfbc_pkg::EXP_BIAS};
    shl    = ep - {6'd0, bfbc_pkg::MANT_TOP};
    ne     = (bfbc_pkg::EXP_BIAS - 11'd1) - expf;
    f0     = '0;
    data_next.sgn = value_bits[63];
    if (expf >= bfbc_pkg::EXP_BIAS) begin
      // Fraction bits sit below the binary point of the shifted mantissa.
      if (ep >= 12'd52 || dec_width == 6'd0) begin
        data_next.frac = '0;
      end else begin
        data_next.frac = (mant64 << (ep[5:0] + 6'd12)) >> (7'd64 - {1'b0, dec_width});
      end
      if (ep <= 12'd52) begin
        data_next.mag = full >> (bfbc_pkg::MANT_TOP - ep[5:0]);
      end else if (shl >= 12'd64) begin
        data_next.mag = '0;
      end else begin
        data_next.mag = full << shl[5:0];
      end
    end else begin
      if (dec_width <= bfbc_pkg::HIDDEN_SPAN) begin
        f0 = full >> (bfbc_pkg::HIDDEN_SPAN - dec_width);
      end else begin
        f0 = full << (dec_width - bfbc_pkg::HIDDEN_SPAN);
      end
      data_next.frac = (ne >= 11'd64) ? '0 : (f0 >> ne[5:0]);
      data_next.mag  = '0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

[sv/bfbc_offset.sv]
module bfbc_offset (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bfbc_pkg::split_t  in_data,
  input  logic [63:0]       neg_lower_bound,
  output logic              out_valid,
  input  logic              out_ready,
  output bfbc_pkg::offset_t out_data
);

  bfbc_pkg::offset_t data_next;

  // Negative values: -mag - lb = ~mag + (-lb) + 1, so one adder with carry-in.
  always_comb begin
    data_next.sgn  = in_data.sgn;
    data_next.frac = in_data.frac;
    data_next.offs = (in_data.sgn ? ~in_data.mag : in_data.mag) + neg_lower_bound
                     + {63'd0, in_data.sgn};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

[sv/bfbc_pack.sv]
module bfbc_pack (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bfbc_pkg::offset_t in_data,
  input  logic [5:0]        dec_width,
  input  logic [5:0]        whole_width,
  output logic              out_valid,
  input  logic              out_ready,
  output bfbc_pkg::packed_t out_data
);

  logic [63:0]       word64;
  logic [63:0]       mask;
  logic [6:0]        ww_ext;
  bfbc_pkg::packed_t data_next;

  always_comb begin
    ww_ext = {1'b0, whole_width};
    mask   = (64'd1 << whole_width) - 64'd1;
    word64 = ({63'd0, in_data.sgn} << (whole_width - 6'd1))
             | (in_data.offs << dec_width) | in_data.frac;
    if (whole_width == 6'd0) begin
      data_next.word = '0;
      data_next.cnt  = '0;
    end else begin
      data_next.word = word64[62:0] & mask[62:0];
      data_next.cnt  = 4'((ww_ext + 7'd7) >> 3);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

[sv/bfbc_columns.sv]
module bfbc_columns (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bfbc_pkg::packed_t in_data,
  input  logic [5:0]        whole_width,
  output logic              out_valid,
  input  logic              out_ready,
  output bfbc_pkg::result_t out_data
);

  logic [63:0]       top;
  logic [7:0]        last_mask;
  logic [3:0]        last_idx;
  bfbc_pkg::result_t data_next;

  always_comb begin
    // Left-justify the word so that the full columns are fixed byte slices.
    top       = {1'b0, in_data.word} << (7'd64 - {1'b0, whole_width});
    last_mask = (whole_width[2:0] == 3'd0) ? 8'hFF : ~(8'hFF << whole_width[2:0]);
    last_idx  = in_data.cnt - 4'd1;
    data_next.word = in_data.word;
    data_next.cnt  = in_data.cnt;
    for (int j = 0; j < bfbc_pkg::NUM_COLS; j++) begin
      if (in_data.cnt == 4'd0 || 4'(j) > last_idx) begin
        data_next.cols[j] = '0;
      end else if (4'(j) == last_idx) begin
        data_next.cols[j] = in_data.word[7:0] & last_mask;
      end else begin
        data_next.cols[j] = top[63-8*j -: 8];
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
